// ----- rtl/tlm_pkg.sv -----
// Shared types and constants for the telemetry limit monitor table.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tlm_pkg;

    localparam int DEFAULT_ENTRY_COUNT = 8;
    localparam int MAX_ENTRY_COUNT     = 12;
    localparam int BYTES_PER_ENTRY     = 5;
    localparam int QUEUE_DEPTH         = 2;

    localparam int FUNC_W   = 3;
    localparam int PID_W    = 8;
    localparam int WORD_W   = 32;
    localparam int ROOM_W   = 16;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int ID_W     = $clog2(MAX_ENTRY_COUNT);
    localparam int BSEL_W   = $clog2(BYTES_PER_ENTRY);

    // function selector codes
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIMITS = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SERIAL = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALARM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ROOM   = 3'd4;

    // byte positions within one serialized entry
    localparam logic [BSEL_W-1:0] BSEL_B3    = 3'd0;
    localparam logic [BSEL_W-1:0] BSEL_B2    = 3'd1;
    localparam logic [BSEL_W-1:0] BSEL_B1    = 3'd2;
    localparam logic [BSEL_W-1:0] BSEL_B0    = 3'd3;
    localparam logic [BSEL_W-1:0] BSEL_FRESH = 3'd4;

    typedef enum logic [2:0] {
        OP_UPDATE,
        OP_READ,
        OP_LIMITS,
        OP_CHECK,
        OP_SERIAL,
        OP_NOP,
        OP_BAD_ID,
        OP_ROOM
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
    } cmd_t;

    // queue push and full flag, driven by the front end
    typedef struct packed {
        logic push;
        logic full;
    } q_ctrl_t;

endpackage

// ----- rtl/tlm_if.sv -----
// Valid/ready channel interfaces for request and result transactions.
// Depends on tlm_pkg.
`timescale 1ns / 1ps

interface tlm_req_if import tlm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [PID_W-1:0]    param_id;
    logic [WORD_W-1:0]   sample_value;
    logic [WORD_W-1:0]   sample_time;
    logic [WORD_W-1:0]   lower_bound;
    logic [WORD_W-1:0]   upper_bound;
    logic [ROOM_W-1:0]   room_bytes;

    modport source (
        output valid, func, param_id, sample_value, sample_time,
               lower_bound, upper_bound, room_bytes,
        input  ready
    );
    modport sink (
        input  valid, func, param_id, sample_value, sample_time,
               lower_bound, upper_bound, room_bytes,
        output ready
    );
endinterface

interface tlm_rsp_if import tlm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   entry_value;
    logic [WORD_W-1:0]   entry_time;
    logic                entry_fresh;
    logic [BYTE_W-1:0]   packed_byte;
    logic [COUNT_W-1:0]  byte_count;
    logic                last;

    modport source (
        output valid, status, entry_value, entry_time, entry_fresh,
               packed_byte, byte_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, entry_value, entry_time, entry_fresh,
               packed_byte, byte_count, last,
        output ready
    );
endinterface

// ----- rtl/tlm_front.sv -----
// Front end: accepts request transactions and decodes them into commands.
// Depends on tlm_pkg and tlm_req_if.
`timescale 1ns / 1ps

module tlm_front import tlm_pkg::*; #(
    parameter int ENTRY_COUNT = DEFAULT_ENTRY_COUNT
) (
    tlm_req_if.sink  req,
    input  logic     q_full,
    output q_ctrl_t  q_ctrl,
    output cmd_t     cmd
);

    localparam int PACKET_BYTES = ENTRY_COUNT * BYTES_PER_ENTRY;

    logic id_good;
    logic room_short;

    assign req.ready   = !q_full;
    assign q_ctrl.push = req.valid && !q_full;
    assign q_ctrl.full = q_full;

    assign id_good    = req.param_id < PID_W'(ENTRY_COUNT);
    assign room_short = req.room_bytes < ROOM_W'(PACKET_BYTES);

    always_comb
    begin
        cmd.id    = req.param_id[ID_W-1:0];
        cmd.value = req.sample_value;
        cmd.stamp = req.sample_time;
        cmd.lo    = req.lower_bound;
        cmd.hi    = req.upper_bound;
        unique case (req.func)
            FUNC_UPDATE: cmd.op = id_good ? OP_UPDATE : OP_BAD_ID;
            FUNC_READ:   cmd.op = id_good ? OP_READ   : OP_BAD_ID;
            FUNC_LIMITS: cmd.op = id_good ? OP_LIMITS : OP_BAD_ID;
            FUNC_CHECK:  cmd.op = id_good ? OP_CHECK  : OP_BAD_ID;
            FUNC_SERIAL: cmd.op = room_short ? OP_ROOM : OP_SERIAL;
            default:     cmd.op = OP_NOP;
        endcase
    end

endmodule

// ----- rtl/tlm_queue.sv -----
// Short command queue between the front end and the table engine.
// Depends on tlm_pkg.
`timescale 1ns / 1ps

module tlm_queue import tlm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign avail   = count_reg != '0;
    assign pop_cmd = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/tlm_back.sv -----
// Table engine: holds the entry stores, executes commands, streams packets.
// Depends on tlm_pkg and tlm_rsp_if.
`timescale 1ns / 1ps

module tlm_back import tlm_pkg::*; #(
    parameter int ENTRY_COUNT = DEFAULT_ENTRY_COUNT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_avail,
    input  cmd_t     q_cmd,
    output logic     q_pop,
    tlm_rsp_if.source rsp
);

    localparam int PACKET_BYTES = ENTRY_COUNT * BYTES_PER_ENTRY;
    localparam int IDX_W        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    typedef enum logic {
        S_IDLE,
        S_SERIAL
    } state_t;

    logic [WORD_W-1:0] value_store [ENTRY_COUNT];
    logic [WORD_W-1:0] time_store  [ENTRY_COUNT];
    logic              fresh_flags [ENTRY_COUNT];
    logic [WORD_W-1:0] low_store   [ENTRY_COUNT];
    logic [WORD_W-1:0] high_store  [ENTRY_COUNT];

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    ent_reg, ent_next;
    logic [BSEL_W-1:0]   bsel_reg, bsel_next;
    logic                valid_reg, valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic [WORD_W-1:0]   time_reg, time_next;
    logic                fresh_reg, fresh_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                last_reg, last_next;

    logic              slot_free;
    logic [IDX_W-1:0]  rd_idx;
    logic [WORD_W-1:0] rd_value;
    logic [WORD_W-1:0] rd_time;
    logic              rd_fresh;
    logic [WORD_W-1:0] rd_low;
    logic [WORD_W-1:0] rd_high;
    logic              wr_sample;
    logic              wr_limits;
    logic              ent_done;

    assign slot_free = !valid_reg || rsp.ready;
    assign q_pop     = (state_reg == S_IDLE) && q_avail && slot_free;
    assign wr_sample = q_pop && (q_cmd.op == OP_UPDATE);
    assign wr_limits = q_pop && (q_cmd.op == OP_LIMITS);
    assign ent_done  = bsel_reg == BSEL_FRESH;

    // one read port, shared by command execution and packet streaming
    assign rd_idx   = (state_reg == S_SERIAL) ? ent_reg : q_cmd.id[IDX_W-1:0];
    assign rd_value = value_store[rd_idx];
    assign rd_time  = time_store[rd_idx];
    assign rd_fresh = fresh_flags[rd_idx];
    assign rd_low   = low_store[rd_idx];
    assign rd_high  = high_store[rd_idx];

    assign rsp.valid       = valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_value = value_reg;
    assign rsp.entry_time  = time_reg;
    assign rsp.entry_fresh = fresh_reg;
    assign rsp.packed_byte = byte_reg;
    assign rsp.byte_count  = count_reg;
    assign rsp.last        = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        bsel_next   = bsel_reg;
        valid_next  = valid_reg && !rsp.ready;
        status_next = status_reg;
        value_next  = value_reg;
        time_next   = time_reg;
        fresh_next  = fresh_reg;
        byte_next   = byte_reg;
        count_next  = count_reg;
        last_next   = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    value_next  = '0;
                    time_next   = '0;
                    fresh_next  = 1'b0;
                    byte_next   = '0;
                    count_next  = '0;
                    last_next   = 1'b1;
                    unique case (q_cmd.op)
                        OP_READ:
                        begin
                            value_next = rd_value;
                            time_next  = rd_time;
                            fresh_next = rd_fresh;
                        end
                        OP_CHECK:
                        begin
                            if (!rd_fresh)
                            begin
                                status_next = ST_STALE;
                            end
                            else if (rd_value < rd_low || rd_value > rd_high)
                            begin
                                status_next = ST_ALARM;
                            end
                        end
                        OP_SERIAL:
                        begin
                            valid_next = 1'b0;
                            state_next = S_SERIAL;
                            ent_next   = '0;
                            bsel_next  = BSEL_B3;
                        end
                        OP_BAD_ID: status_next = ST_BAD_ID;
                        OP_ROOM:   status_next = ST_ROOM;
                        default:   status_next = ST_OK;
                    endcase
                end
            end
            S_SERIAL:
            begin
                if (slot_free)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    value_next  = '0;
                    time_next   = '0;
                    fresh_next  = 1'b0;
                    count_next  = '0;
                    last_next   = 1'b0;
                    case (bsel_reg)
                        BSEL_B3: byte_next = rd_value[31:24];
                        BSEL_B2: byte_next = rd_value[23:16];
                        BSEL_B1: byte_next = rd_value[15:8];
                        BSEL_B0: byte_next = rd_value[7:0];
                        default: byte_next = BYTE_W'(rd_fresh);
                    endcase
                    if (ent_done)
                    begin
                        bsel_next = BSEL_B3;
                        if (ent_reg == IDX_W'(ENTRY_COUNT - 1))
                        begin
                            last_next  = 1'b1;
                            count_next = COUNT_W'(PACKET_BYTES);
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ent_next = ent_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        bsel_next = bsel_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ent_reg   <= '0;
            bsel_reg  <= BSEL_B3;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ent_reg   <= ent_next;
            bsel_reg  <= bsel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        time_reg   <= time_next;
        fresh_reg  <= fresh_next;
        byte_reg   <= byte_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                value_store[i] <= '0;
                time_store[i]  <= '0;
                fresh_flags[i] <= 1'b0;
                low_store[i]   <= '0;
                high_store[i]  <= '0;
            end
        end
        else
        begin
            if (wr_sample)
            begin
                value_store[rd_idx] <= q_cmd.value;
                time_store[rd_idx]  <= q_cmd.stamp;
                fresh_flags[rd_idx] <= 1'b1;
            end
            if (wr_limits)
            begin
                low_store[rd_idx]  <= q_cmd.lo;
                high_store[rd_idx] <= q_cmd.hi;
            end
        end
    end

endmodule

// ----- rtl/telemetry_limit_monitor_table.sv -----
// An accepted request is written into the command queue; the engine then pops it and
// registers its result; a serialize request first puts the engine in its serial state.
// Throughput: one request per cycle for update, read, set limits, check and refusals,
// and one serialize byte per cycle via the single output register, while rsp is ready;
// during a serialize the two-entry queue takes two more requests, then stalls.
// Reset (async, active low) clears all entry stores, the queue and rsp.valid.
`timescale 1ns / 1ps

module telemetry_limit_monitor_table import tlm_pkg::*; #(
    parameter int ENTRY_COUNT = DEFAULT_ENTRY_COUNT
) (
    input  logic      clk,
    input  logic      rst_n,
    tlm_req_if.sink   req,
    tlm_rsp_if.source rsp
);

    q_ctrl_t q_ctrl;
    cmd_t    front_cmd;
    cmd_t    back_cmd;
    logic    q_full;
    logic    q_avail;
    logic    q_pop;

    tlm_front #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .q_ctrl (q_ctrl),
        .cmd    (front_cmd)
    );

    tlm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_ctrl.push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_cmd  (back_cmd)
    );

    tlm_back #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_cmd   (back_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

    // never write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.push |-> !q_ctrl.full)
        else $error("command queue overflow");

    // popping from an empty queue would replay a stale command
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_avail)
        else $error("command queue underflow");

    // the packet length only rides on the closing byte
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.byte_count != '0 |-> rsp.last && rsp.status == ST_OK)
        else $error("byte count on a non-final result");

    // entry data is only returned by a successful read
    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |->
            rsp.entry_value == '0 && rsp.entry_time == '0 && !rsp.entry_fresh)
        else $error("entry data on an error result");

endmodule

// ----- tb/table_result_checker.sv -----
// Checker for the telemetry limit monitor table: watches both channels, keeps its
// own copy of the entry stores and compares every result transaction in order.
// Depends on tlm_pkg and the channel interfaces in tlm_if.sv.
`timescale 1ns / 1ps

module table_result_checker import tlm_pkg::*; #(
    parameter int ENTRY_COUNT = DEFAULT_ENTRY_COUNT
) (
    input  logic clk,
    input  logic rst_n,
    tlm_req_if   req,
    tlm_rsp_if   rsp,
    output int   mismatches,
    output int   awaited_count
);

    localparam int PACKET_LEN = ENTRY_COUNT * BYTES_PER_ENTRY;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   value;
        logic [WORD_W-1:0]   stamp;
        logic                fresh;
        logic [BYTE_W-1:0]   data;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } table_result_t;

    logic [WORD_W-1:0] value_mem [ENTRY_COUNT];
    logic [WORD_W-1:0] stamp_mem [ENTRY_COUNT];
    logic              fresh_mem [ENTRY_COUNT];
    logic [WORD_W-1:0] low_mem   [ENTRY_COUNT];
    logic [WORD_W-1:0] high_mem  [ENTRY_COUNT];

    table_result_t pending_results [$];
    int            fail_tally;

    initial
    begin
        fail_tally    = 0;
        mismatches    = 0;
        awaited_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_tally++;
    endtask

    task automatic field_check(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic table_result_t single_result(input logic [STATUS_W-1:0] st);
        table_result_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // expected results of one accepted request; updates the shadow stores
    task automatic predict_results(input logic [FUNC_W-1:0] func,
                                   input logic [PID_W-1:0]  id,
                                   input logic [WORD_W-1:0] sval,
                                   input logic [WORD_W-1:0] stim,
                                   input logic [WORD_W-1:0] lo,
                                   input logic [WORD_W-1:0] hi,
                                   input logic [ROOM_W-1:0] room);
        table_result_t r;
        int            e;
        e = int'(id);
        if (func == FUNC_SERIAL)
        begin
            if (int'(room) < PACKET_LEN)
            begin
                pending_results.push_back(single_result(ST_ROOM));
            end
            else
            begin
                for (int i = 0; i < ENTRY_COUNT; i++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        r      = '0;
                        r.data = value_mem[i][31 - 8*b -: 8];
                        pending_results.push_back(r);
                    end
                    r      = '0;
                    r.data = {7'd0, fresh_mem[i]};
                    if (i == ENTRY_COUNT - 1)
                    begin
                        r.count = COUNT_W'(PACKET_LEN);
                        r.last  = 1'b1;
                    end
                    pending_results.push_back(r);
                end
            end
        end
        else if (func > FUNC_SERIAL)
        begin
            pending_results.push_back(single_result(ST_OK));
        end
        else if (e >= ENTRY_COUNT)
        begin
            pending_results.push_back(single_result(ST_BAD_ID));
        end
        else
        begin
            r = single_result(ST_OK);
            case (func)
                FUNC_UPDATE:
                begin
                    value_mem[e] = sval;
                    stamp_mem[e] = stim;
                    fresh_mem[e] = 1'b1;
                end
                FUNC_READ:
                begin
                    r.value = value_mem[e];
                    r.stamp = stamp_mem[e];
                    r.fresh = fresh_mem[e];
                end
                FUNC_LIMITS:
                begin
                    low_mem[e]  = lo;
                    high_mem[e] = hi;
                end
                default:
                begin
                    if (!fresh_mem[e])
                        r.status = ST_STALE;
                    else if (value_mem[e] < low_mem[e] || value_mem[e] > high_mem[e])
                        r.status = ST_ALARM;
                end
            endcase
            pending_results.push_back(r);
        end
    endtask

    task automatic compare_result();
        table_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending, status %0d byte %h",
                                      rsp.status, rsp.packed_byte));
        end
        else
        begin
            want = pending_results.pop_front();
            field_check("status", WORD_W'(rsp.status), WORD_W'(want.status));
            field_check("entry_value", rsp.entry_value, want.value);
            field_check("entry_time", rsp.entry_time, want.stamp);
            field_check("entry_fresh", WORD_W'(rsp.entry_fresh), WORD_W'(want.fresh));
            field_check("packed_byte", WORD_W'(rsp.packed_byte), WORD_W'(want.data));
            field_check("byte_count", WORD_W'(rsp.byte_count), WORD_W'(want.count));
            field_check("last", WORD_W'(rsp.last), WORD_W'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                value_mem[i] = '0;
                stamp_mem[i] = '0;
                fresh_mem[i] = 1'b0;
                low_mem[i]   = '0;
                high_mem[i]  = '0;
            end
            pending_results.delete();
            awaited_count <= 0;
        end
        else
        begin
            // a result never belongs to a request accepted at the same edge
            if (rsp.valid && rsp.ready)
                compare_result();
            if (req.valid && req.ready)
                predict_results(req.func, req.param_id, req.sample_value, req.sample_time,
                                req.lower_bound, req.upper_bound, req.room_bytes);
            awaited_count <= pending_results.size();
            mismatches    <= fail_tally;
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top of the telemetry limit monitor table testbench: clock, reset, request
// stimulus with random idling and result back-pressure, watchdog and verdict.
// Depends on tlm_pkg, tlm_if.sv, the block and table_result_checker.
`timescale 1ns / 1ps

module tb;
    import tlm_pkg::*;

    localparam int ENTRY_COUNT  = DEFAULT_ENTRY_COUNT;
    localparam int PACKET_LEN   = ENTRY_COUNT * BYTES_PER_ENTRY;
    localparam int PHASE_ITEMS  = 60;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_SERIAL + 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = {FUNC_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PID_W-1:0]  param_id;
        logic [WORD_W-1:0] sample_value;
        logic [WORD_W-1:0] sample_time;
        logic [WORD_W-1:0] lower_bound;
        logic [WORD_W-1:0] upper_bound;
        logic [ROOM_W-1:0] room_bytes;
    } req_item_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   awaited_count;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles;

    logic [WORD_W-1:0] last_written [ENTRY_COUNT];

    tlm_req_if req_ch ();
    tlm_rsp_if rsp_ch ();

    telemetry_limit_monitor_table #(
        .ENTRY_COUNT(ENTRY_COUNT)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    table_result_checker #(
        .ENTRY_COUNT(ENTRY_COUNT)
    ) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .mismatches   (mismatches),
        .awaited_count(awaited_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("** telemetry_limit_monitor_table: FAILED **");
            $finish;
        end
    end

    task automatic send_request(input req_item_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= item.func;
        req_ch.param_id     <= item.param_id;
        req_ch.sample_value <= item.sample_value;
        req_ch.sample_time  <= item.sample_time;
        req_ch.lower_bound  <= item.lower_bound;
        req_ch.upper_bound  <= item.upper_bound;
        req_ch.room_bytes   <= item.room_bytes;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (item.func == FUNC_UPDATE && int'(item.param_id) < ENTRY_COUNT)
            last_written[int'(item.param_id)] = item.sample_value;
        @(negedge clk);
    endtask

    task automatic issue(input logic [FUNC_W-1:0] func, input logic [PID_W-1:0] id,
                         input logic [WORD_W-1:0] sval, input logic [WORD_W-1:0] stim,
                         input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                         input logic [ROOM_W-1:0] room);
        req_item_t item;
        item = '{func, id, sval, stim, lo, hi, room};
        send_request(item);
    endtask

    // mostly in-range ids, limits placed around the last written value
    function automatic req_item_t random_item();
        req_item_t         it;
        int                pick;
        logic [WORD_W-1:0] v;
        pick            = $urandom_range(99);
        it.sample_value = $urandom;
        it.sample_time  = $urandom;
        it.lower_bound  = $urandom;
        it.upper_bound  = $urandom;
        it.param_id     = ($urandom_range(9) == 0) ? PID_W'($urandom_range(255))
                                                   : PID_W'($urandom_range(ENTRY_COUNT - 1));
        it.room_bytes   = ($urandom_range(4) == 0) ? ROOM_W'($urandom_range(PACKET_LEN - 1))
                                                   : ROOM_W'($urandom_range(65535, PACKET_LEN));
        if (pick < 28)
            it.func = FUNC_UPDATE;
        else if (pick < 46)
            it.func = FUNC_READ;
        else if (pick < 62)
            it.func = FUNC_LIMITS;
        else if (pick < 84)
            it.func = FUNC_CHECK;
        else if (pick < 92)
            it.func = FUNC_SERIAL;
        else
            it.func = FUNC_W'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
        v = last_written[int'(it.param_id) % ENTRY_COUNT];
        if (it.func == FUNC_UPDATE && $urandom_range(1) == 0)
            it.sample_value = v + WORD_W'($urandom_range(4)) - 32'd2;
        if (it.func == FUNC_LIMITS)
        begin
            case ($urandom_range(3))
                0:
                begin
                    it.lower_bound = v - WORD_W'($urandom_range(2));
                    it.upper_bound = v + WORD_W'($urandom_range(2));
                end
                1:
                begin
                    it.lower_bound = v + 32'd1;
                    it.upper_bound = v + 32'd1 + WORD_W'($urandom_range(15));
                end
                2:
                begin
                    it.upper_bound = v - 32'd1;
                    it.lower_bound = v - 32'd1 - WORD_W'($urandom_range(15));
                end
                default:
                begin
                end
            endcase
        end
        return it;
    endfunction

    initial
    begin
        rst_n               = 1'b0;
        quiet_cycles        = 0;
        idle_pct            = 0;
        stall_pct           = 0;
        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_UPDATE;
        req_ch.param_id     = '0;
        req_ch.sample_value = '0;
        req_ch.sample_time  = '0;
        req_ch.lower_bound  = '0;
        req_ch.upper_bound  = '0;
        req_ch.room_bytes   = '0;
        rsp_ch.ready        = 1'b0;
        for (int i = 0; i < ENTRY_COUNT; i++)
            last_written[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset contents, boundaries and every function
        issue(FUNC_CHECK, 8'd0, '0, '0, '0, '0, '0);
        issue(FUNC_READ, 8'd0, '0, '0, '0, '0, '0);
        issue(FUNC_SERIAL, 8'd0, '0, '0, '0, '0, ROOM_W'(PACKET_LEN));
        issue(FUNC_SERIAL, 8'd0, '0, '0, '0, '0, ROOM_W'(PACKET_LEN - 1));
        issue(FUNC_SERIAL, 8'd0, '0, '0, '0, '0, '0);
        issue(FUNC_UPDATE, 8'd0, '1, '1, '0, '0, '0);
        issue(FUNC_UPDATE, PID_W'(ENTRY_COUNT - 1), '0, '0, '1, '1, '1);
        issue(FUNC_UPDATE, PID_W'(ENTRY_COUNT), '1, '1, '1, '1, '1);
        issue(FUNC_UPDATE, 8'hFF, '1, '1, '0, '0, '0);
        issue(FUNC_READ, 8'hFF, '0, '0, '0, '0, '0);
        issue(FUNC_LIMITS, PID_W'(ENTRY_COUNT), '0, '0, '0, '1, '0);
        issue(FUNC_CHECK, 8'd200, '0, '0, '0, '0, '0);
        issue(FUNC_READ, 8'd0, '0, '0, '0, '0, '0);
        issue(FUNC_CHECK, 8'd0, '0, '0, '0, '0, '0);
        issue(FUNC_LIMITS, 8'd0, '0, '0, '0, '1, '0);
        issue(FUNC_CHECK, 8'd0, '0, '0, '0, '0, '0);
        // inverted limits alarm even for a value between them
        issue(FUNC_LIMITS, PID_W'(ENTRY_COUNT - 1), '0, '0, 32'd5, 32'd3, '0);
        issue(FUNC_UPDATE, PID_W'(ENTRY_COUNT - 1), 32'd4, 32'h8000_0001, '0, '0, '0);
        issue(FUNC_CHECK, PID_W'(ENTRY_COUNT - 1), '0, '0, '0, '0, '0);
        issue(FUNC_LIMITS, PID_W'(ENTRY_COUNT - 1), '0, '0, 32'd4, 32'd4, '0);
        issue(FUNC_CHECK, PID_W'(ENTRY_COUNT - 1), '0, '0, '0, '0, '0);
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            issue(FUNC_W'(f), 8'd3, '1, '1, '1, '1, '1);
        issue(FUNC_UPDATE, 8'd3, 32'h1234_5678, 32'h0BAD_F00D, '0, '0, '0);
        issue(FUNC_SERIAL, 8'hFF, '0, '0, '0, '0, '1);

        // random, one phase per idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_item());
        end
        req_ch.valid <= 1'b0;

        while (awaited_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_count == 0)
            $display("** telemetry_limit_monitor_table: PASSED **");
        else
            $display("** telemetry_limit_monitor_table: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tlm_pkg.sv
rtl/tlm_if.sv
rtl/tlm_front.sv
rtl/tlm_queue.sv
rtl/tlm_back.sv
rtl/telemetry_limit_monitor_table.sv
tb/table_result_checker.sv
tb/tb.sv
